/* rtl/core/ofdm_cyclic_prefix_removal_core_defines.svh */
// assertion macros shared by the checker of the ofdm cyclic prefix removal core
// no dependencies; included by files that carry concurrent assertions
`ifndef OFDM_CYCLIC_PREFIX_REMOVAL_CORE_DEFINES_SVH
`define OFDM_CYCLIC_PREFIX_REMOVAL_CORE_DEFINES_SVH

// clocked assertion, switched off while reset is held low
`define OCPR_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// clocked assertion that also holds during reset
`define OCPR_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("%m: assertion failed");

`endif

/* rtl/core/ocpr_pkg.sv */
// shared types and constants of the ofdm cyclic prefix removal core
// no dependencies; imported by every module of the core
`default_nettype none

package ocpr_pkg;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned CNT_W  = 32;

  // defaults of the top level parameters
  localparam int unsigned DEF_TRANSFORM_SIZE   = 64;
  localparam int unsigned DEF_MODULE_ID_BITS   = 8;
  localparam int unsigned DEF_PARAM_ID_BITS    = 8;
  localparam int unsigned DEF_PARAM_VALUE_BITS = 48;
  localparam int unsigned DEF_OWN_MODULE_ID    = 7;

  // parameter ids of header words addressed to this block
  localparam int unsigned PID_DLEN      = 0;
  localparam int unsigned PID_SYM_NUM   = 1;
  localparam int unsigned PID_PILOT     = 2;
  localparam int unsigned PID_PREFIX    = 3;

  // serial divider geometry
  localparam int unsigned DIV_DVD_W = 64;
  localparam int unsigned DIV_DVS_W = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_DVD_W);

  typedef struct packed {
    logic take_hdr;      // accept header words
    logic take_data;     // accept sample words
    logic load_prod;     // register data length times symbol count
    logic start_pilot;   // divide transform size by pilot spacing
    logic start_blocks;  // divide product by useful carriers per symbol
    logic set_total;     // store saturated quotient as block total
    logic clear_total;   // zero blocks
  } ocpr_cmd_t;

  typedef struct packed {
    logic term_acc;      // terminator word accepted
    logic pilot_zero;
    logic div_done;
    logic per_zero;      // carriers per symbol is zero
    logic quot_zero;
    logic frame_end;     // last word of last block accepted
  } ocpr_sts_t;

endpackage

`default_nettype wire

/* rtl/core/ofdm_cyclic_prefix_removal_core.sv */
// Cyclic prefix removal for an OFDM receive stream. Header words (module id, parameter
// id, value) addressed to OWN_MODULE_ID set data length, symbol count, pilot spacing and
// prefix length and are consumed; other header words pass with tlast low. A word whose
// module id is all ones ends the header. The core then computes the block count
// length*symbols/(TRANSFORM_SIZE - TRANSFORM_SIZE/pilot) and, per block, drops the
// prefix words and forwards TRANSFORM_SIZE samples with their tlast. Header and sample
// words are taken one per cycle while the output is taken. After the terminator word
// the core takes no input while it registers the product and starts the bit-serial
// divider, divides TRANSFORM_SIZE by the pilot spacing and then the product by the
// useful carriers. A zero pilot spacing skips both divisions, no useful carriers the second.
// depends on ocpr_pkg, ocpr_ctrl and ocpr_datapath
`default_nettype none

module ofdm_cyclic_prefix_removal_core import ocpr_pkg::*; #(
  parameter int unsigned TRANSFORM_SIZE   = DEF_TRANSFORM_SIZE,
  parameter int unsigned MODULE_ID_BITS   = DEF_MODULE_ID_BITS,
  parameter int unsigned PARAM_ID_BITS    = DEF_PARAM_ID_BITS,
  parameter int unsigned PARAM_VALUE_BITS = DEF_PARAM_VALUE_BITS,
  parameter int unsigned OWN_MODULE_ID    = DEF_OWN_MODULE_ID
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [DATA_W-1:0] s_axis_tdata,   // [63:0] in_data
  input  wire logic              s_axis_tlast,   // in_last
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [DATA_W-1:0]      m_axis_tdata,   // [63:0] out_data
  output logic                   m_axis_tlast    // out_last
);

  ocpr_cmd_t cmd;
  ocpr_sts_t sts;

  ocpr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  ocpr_datapath #(
    .TRANSFORM_SIZE   (TRANSFORM_SIZE),
    .MODULE_ID_BITS   (MODULE_ID_BITS),
    .PARAM_ID_BITS    (PARAM_ID_BITS),
    .PARAM_VALUE_BITS (PARAM_VALUE_BITS),
    .OWN_MODULE_ID    (OWN_MODULE_ID)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

/* rtl/core/ocpr_divider.sv */
// bit-serial restoring divider, one quotient bit per cycle
// depends on ocpr_pkg
`default_nettype none

module ocpr_divider import ocpr_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DIV_DVD_W-1:0] dividend_i,
  input  wire logic [DIV_DVS_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [DIV_DVD_W-1:0]      quot_o
);

  logic [DIV_DVD_W-1:0] dvd_q, dvd_d;
  logic [DIV_DVS_W-1:0] dvs_q;
  logic [DIV_DVS_W-1:0] rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [DIV_DVS_W:0]   shifted;
  logic                 qbit;

  always_comb begin
    shifted = {rem_q, dvd_q[DIV_DVD_W-1]};
    qbit    = shifted >= {1'b0, dvs_q};
    rem_d   = qbit ? DIV_DVS_W'(shifted - {1'b0, dvs_q}) : shifted[DIV_DVS_W-1:0];
    dvd_d   = {dvd_q[DIV_DVD_W-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend register shifts out dividend bits and collects quotient bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

`default_nettype wire

/* rtl/core/ocpr_datapath.sv */
// header decode, parameter registers, block counters and output register
// depends on ocpr_pkg and ocpr_divider
`default_nettype none

module ocpr_datapath import ocpr_pkg::*; #(
  parameter int unsigned TRANSFORM_SIZE   = DEF_TRANSFORM_SIZE,
  parameter int unsigned MODULE_ID_BITS   = DEF_MODULE_ID_BITS,
  parameter int unsigned PARAM_ID_BITS    = DEF_PARAM_ID_BITS,
  parameter int unsigned PARAM_VALUE_BITS = DEF_PARAM_VALUE_BITS,
  parameter int unsigned OWN_MODULE_ID    = DEF_OWN_MODULE_ID
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ocpr_cmd_t         cmd_i,
  output ocpr_sts_t              sts_o,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [DATA_W-1:0] s_axis_tdata,   // [63:0] in_data
  input  wire logic              s_axis_tlast,   // in_last
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [DATA_W-1:0]      m_axis_tdata,   // [63:0] out_data
  output logic                   m_axis_tlast    // out_last
);

  localparam int unsigned IdShift = PARAM_ID_BITS + PARAM_VALUE_BITS;
  localparam logic [DATA_W-1:0] ValMask = (DATA_W'(1) << PARAM_VALUE_BITS) - DATA_W'(1);

  logic [DATA_W-1:0]         hi_w, pid_sh_w, val_w;
  logic [MODULE_ID_BITS-1:0] mod_id_w;
  logic [PARAM_ID_BITS-1:0]  pid_w;
  logic                      own_w, term_w;
  logic                      acc, acc_hdr, acc_data;
  logic                      emit_data, seg_end, blk_end;
  logic [CNT_W-1:0]          blk_next;

  logic [CNT_W-1:0]     dlen_q, sym_num_q, pilot_q, prefix_q;
  logic [CNT_W-1:0]     total_q, blk_q, smp_q;
  logic [CNT_W-1:0]     total_d;
  logic [DATA_W-1:0]    prod_q;
  logic                 out_valid_q, out_last_q;
  logic [DATA_W-1:0]    out_data_q;

  logic                 div_start, div_done;
  logic [DIV_DVD_W-1:0] div_dvd, div_quot;
  logic [DIV_DVS_W-1:0] div_dvs, per_w;

  // header word fields
  always_comb begin
    hi_w     = s_axis_tdata >> IdShift;
    mod_id_w = hi_w[MODULE_ID_BITS-1:0];
    pid_sh_w = s_axis_tdata >> PARAM_VALUE_BITS;
    pid_w    = pid_sh_w[PARAM_ID_BITS-1:0];
    val_w    = s_axis_tdata & ValMask;
    own_w    = DATA_W'(mod_id_w) == DATA_W'(OWN_MODULE_ID);
    term_w   = &mod_id_w;
  end

  assign s_axis_tready = (cmd_i.take_hdr || cmd_i.take_data) && (!out_valid_q || m_axis_tready);
  assign acc      = s_axis_tvalid && s_axis_tready;
  assign acc_hdr  = acc && cmd_i.take_hdr;
  assign acc_data = acc && cmd_i.take_data;

  // sample position within the prefix plus transform period
  always_comb begin
    emit_data = smp_q >= prefix_q;
    seg_end   = ({1'b0, smp_q} + 33'd1) >= ({1'b0, prefix_q} + 33'(TRANSFORM_SIZE));
    blk_next  = blk_q + 1'b1;
    blk_end   = blk_next >= total_q;
  end

  // carriers per symbol: transform size less pilot positions
  assign per_w     = DIV_DVS_W'(TRANSFORM_SIZE) - div_quot[DIV_DVS_W-1:0];
  assign div_start = cmd_i.start_pilot || cmd_i.start_blocks;
  assign div_dvd   = cmd_i.start_blocks ? prod_q : DIV_DVD_W'(TRANSFORM_SIZE);
  assign div_dvs   = cmd_i.start_blocks ? per_w : pilot_q;
  assign total_d   = (|div_quot[DIV_DVD_W-1:CNT_W]) ? '1 : div_quot[CNT_W-1:0];

  ocpr_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dlen_q    <= '0;
      sym_num_q <= '0;
      pilot_q   <= '0;
      prefix_q  <= '0;
    end else if (acc_hdr && own_w) begin
      if (pid_w == PARAM_ID_BITS'(PID_DLEN)) begin
        dlen_q <= val_w[CNT_W-1:0];
      end else if (pid_w == PARAM_ID_BITS'(PID_SYM_NUM)) begin
        sym_num_q <= val_w[CNT_W-1:0];
      end else if (pid_w == PARAM_ID_BITS'(PID_PILOT)) begin
        pilot_q <= val_w[CNT_W-1:0];
      end else if (pid_w == PARAM_ID_BITS'(PID_PREFIX)) begin
        prefix_q <= val_w[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_prod) begin
      prod_q <= DATA_W'(dlen_q) * DATA_W'(sym_num_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      blk_q   <= '0;
      smp_q   <= '0;
    end else if (cmd_i.set_total || cmd_i.clear_total) begin
      total_q <= cmd_i.set_total ? total_d : '0;
      blk_q   <= '0;
      smp_q   <= '0;
    end else if (acc_data) begin
      if (seg_end) begin
        smp_q <= '0;
        blk_q <= blk_end ? '0 : blk_next;
      end else begin
        smp_q <= smp_q + 1'b1;
      end
    end
  end

  // output register parts the two sides of the stream
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((acc_hdr && !own_w) || (acc_data && emit_data)) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((acc_hdr && !own_w) || (acc_data && emit_data)) begin
      out_data_q <= s_axis_tdata;
      out_last_q <= acc_data && s_axis_tlast;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  always_comb begin
    sts_o.term_acc   = acc_hdr && term_w;
    sts_o.pilot_zero = pilot_q == '0;
    sts_o.div_done   = div_done;
    sts_o.per_zero   = per_w == '0;
    sts_o.quot_zero  = div_quot == '0;
    sts_o.frame_end  = acc_data && seg_end && blk_end;
  end

endmodule

`default_nettype wire

/* rtl/core/ocpr_ctrl.sv */
// phase controller: header, block count computation and data phase
// depends on ocpr_pkg
`default_nettype none

module ocpr_ctrl import ocpr_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire ocpr_sts_t sts_i,
  output ocpr_cmd_t      cmd_o
);

  localparam logic [2:0] S_HDR  = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_DIV1 = 3'd2;
  localparam logic [2:0] S_DIV2 = 3'd3;
  localparam logic [2:0] S_DATA = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_HDR: begin
        cmd_o.take_hdr = 1'b1;
        if (sts_i.term_acc) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.load_prod = 1'b1;
        if (sts_i.pilot_zero) begin
          cmd_o.clear_total = 1'b1;
          state_d           = S_HDR;
        end else begin
          cmd_o.start_pilot = 1'b1;
          state_d           = S_DIV1;
        end
      end
      S_DIV1: begin
        if (sts_i.div_done) begin
          if (sts_i.per_zero) begin
            cmd_o.clear_total = 1'b1;
            state_d           = S_HDR;
          end else begin
            cmd_o.start_blocks = 1'b1;
            state_d            = S_DIV2;
          end
        end
      end
      S_DIV2: begin
        if (sts_i.div_done) begin
          cmd_o.set_total = 1'b1;
          state_d         = sts_i.quot_zero ? S_HDR : S_DATA;
        end
      end
      S_DATA: begin
        cmd_o.take_data = 1'b1;
        if (sts_i.frame_end) begin
          state_d = S_HDR;
        end
      end
      default: begin
        state_d = S_HDR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_HDR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ocpr_checker.sv */
// port-level checks of the ofdm cyclic prefix removal core, bound to the top level
// depends on ocpr_pkg and ofdm_cyclic_prefix_removal_core_defines.svh
`default_nettype none
`include "ofdm_cyclic_prefix_removal_core_defines.svh"

module ocpr_checker import ocpr_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              s_axis_tvalid,
  input wire logic              s_axis_tready,
  input wire logic              m_axis_tvalid,
  input wire logic              m_axis_tready,
  input wire logic [DATA_W-1:0] m_axis_tdata,
  input wire logic              m_axis_tlast
);

  // a stalled output transaction keeps its payload
  `OCPR_ASSERT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
  // a stalled output transaction is not withdrawn
  `OCPR_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  // a new output word only follows an accepted input word
  `OCPR_ASSERT(a_out_cause, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
  // input is taken only when the output register can make room
  `OCPR_ASSERT(a_in_room, clk_i, rst_ni, s_axis_tready |-> !m_axis_tvalid || m_axis_tready)

endmodule

bind ofdm_cyclic_prefix_removal_core ocpr_checker u_checker (.*);

`default_nettype wire
